>>> design/bsst_pkg.sv
// ---------------------------------------------------------------------------
// bsst_pkg: shared types and constants for the span tracker
// Widths, status codes, the cell link types and the signed order key.
// ---------------------------------------------------------------------------
package bsst_pkg;

  localparam int MaxCap     = 64;
  localparam int IdxW       = $clog2(MaxCap);
  localparam int CntW       = IdxW + 1;
  localparam int ValW       = 32;
  localparam int StW        = 2;
  localparam int CapW       = 7;
  localparam int MinForSpan = 2;

  localparam logic [StW-1:0] StOk   = 2'd0;
  localparam logic [StW-1:0] StFull = 2'd1;
  localparam logic [StW-1:0] StFew  = 2'd2;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  // handed from each cell to its right-hand neighbour
  typedef struct packed {
    logic            gt;
    logic [ValW-1:0] value;
  } link_t;

  // neighbour-selection flags reported by each cell
  typedef struct packed {
    logic pred;
    logic succ;
    logic last;
  } pick_t;

  // signed order as unsigned compare after flipping the sign bit
  function automatic logic [ValW-1:0] order_key(input logic [ValW-1:0] v);
    order_key = {~v[ValW-1], v[ValW-2:0]};
  endfunction

endpackage

>>> design/bounded_set_span_tracker.sv
// ---------------------------------------------------------------------------
// bounded_set_span_tracker: bounded sorted multiset with min gap and range
// Sorted insertion chain of cells; running minimum neighbour gap; spans on
// query.
// ---------------------------------------------------------------------------
//  channel  | handshake                          | payload
//  ---------+------------------------------------+------------------------------
//  command  | start & !busy                      | op_i, value_i
//  result   | result_valid_o (one cycle)         | status_o, shortest_span_o,
//           |                                    | longest_span_o, count_o
//  config   | psel & penable & pwrite & pready   | paddr, pwdata (capacity)
//
// An item takes a compare/shift step in the cell chain (busy high), then a
// gap-update step in which the result is strobed. A new command is taken in
// that gap-update step, so the next item overlaps the last one's result.
// Reset clears count, sets capacity to 64 and the running gap to all ones;
// cell contents are undefined until written. Results cannot be stalled.
// ---------------------------------------------------------------------------
module bounded_set_span_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [bsst_pkg::ValW-1:0]    value_i,
  output logic                         result_valid_o,
  output logic [bsst_pkg::StW-1:0]     status_o,
  output logic [bsst_pkg::ValW-1:0]    shortest_span_o,
  output logic [bsst_pkg::ValW-1:0]    longest_span_o,
  output logic [bsst_pkg::CntW-1:0]    count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bsst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic            op_q;
  logic [ValW-1:0] x_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CapW-1:0] cap_q;
  logic [ValW-1:0] least_gap_q, least_gap_d;
  logic [StW-1:0]  status_q, status_d;
  logic [ValW-1:0] longest_q, longest_d;
  logic [ValW-1:0] pred_q, succ_q;
  logic            has_pred_q, has_succ_q, add_ok_q;

  logic            accept, cfg_wr, insert, full;
  logic [CntW-1:0] limit;
  link_t           links [MaxCap];
  pick_t           picks [MaxCap];
  logic            right_gt [MaxCap];
  logic [ValW-1:0] pred_v, succ_v, last_v;
  logic            pred_any, succ_any;
  logic [ValW-1:0] gap_p, gap_s, gap_min;

  assign accept = start && !busy;
  assign busy   = state_q == S_EXEC;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata = {{(32-CapW){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(MaxCap);
    end else if (cfg_wr) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  // capacity saturates at the chain length
  assign limit = (CntW'(cap_q) > CntW'(MaxCap)) ? CntW'(MaxCap) : CntW'(cap_q);
  assign full  = (count_q >= limit) || (count_q >= CntW'(MaxCap));
  assign insert = (state_q == S_EXEC) && (op_q == OpAdd) && !full;

  // cell chain
  for (genvar g = 0; g < MaxCap; g++) begin : g_cell
    link_t left;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = links[g-1];
    end
    if (g == MaxCap - 1) begin : g_tail
      assign right_gt[g] = 1'b0;
    end else begin : g_mid
      assign right_gt[g] = links[g+1].gt;
    end
    bsst_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IdxW'(g)),
      .count_i    (count_q),
      .x_i        (x_q),
      .insert_i   (insert),
      .left_i     (left),
      .right_gt_i (right_gt[g]),
      .link_o     (links[g]),
      .pick_o     (picks[g])
    );
  end

  // one-hot selection of neighbours and the last value
  always_comb begin
    pred_v   = '0;
    succ_v   = '0;
    last_v   = '0;
    pred_any = 1'b0;
    succ_any = 1'b0;
    for (int i = 0; i < MaxCap; i++) begin
      pred_v   = pred_v | ({ValW{picks[i].pred}} & links[i].value);
      succ_v   = succ_v | ({ValW{picks[i].succ}} & links[i].value);
      last_v   = last_v | ({ValW{picks[i].last}} & links[i].value);
      pred_any = pred_any | picks[i].pred;
      succ_any = succ_any | picks[i].succ;
    end
  end

  always_comb begin
    status_d  = StOk;
    longest_d = '0;
    count_d   = count_q;
    if (op_q == OpAdd) begin
      if (full) begin
        status_d = StFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (count_q < CntW'(MinForSpan)) begin
      status_d = StFew;
    end else begin
      longest_d = last_v - links[0].value;
    end
  end

  // running minimum neighbour gap
  assign gap_p = has_pred_q ? (x_q - pred_q) : '1;
  assign gap_s = has_succ_q ? (succ_q - x_q) : '1;
  assign gap_min = (gap_p < gap_s) ? gap_p : gap_s;

  always_comb begin
    least_gap_d = least_gap_q;
    if ((state_q == S_DONE) && add_ok_q && (gap_min < least_gap_q)) begin
      least_gap_d = gap_min;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_DONE;
      S_DONE:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      least_gap_q <= '1;
      add_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      least_gap_q <= least_gap_d;
      if (state_q == S_EXEC) begin
        count_q  <= count_d;
        add_ok_q <= insert;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
      x_q  <= value_i;
    end
    if (state_q == S_EXEC) begin
      status_q   <= status_d;
      longest_q  <= longest_d;
      pred_q     <= pred_v;
      succ_q     <= succ_v;
      has_pred_q <= pred_any;
      has_succ_q <= succ_any;
    end
  end

  assign result_valid_o  = state_q == S_DONE;
  assign status_o        = status_q;
  assign longest_span_o  = longest_q;
  assign count_o         = count_q;
  assign shortest_span_o = ((op_q == OpQuery) && (status_q == StOk)) ? least_gap_q : '0;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxCap))
    else $error("count beyond chain length");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("missing result two cycles after accept");

  a_gap_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> least_gap_q <= $past(least_gap_q))
    else $error("running gap increased");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |=> $stable(count_q))
    else $error("count changed outside the shift cycle");

endmodule

>>> design/bsst_cell.sv
// ---------------------------------------------------------------------------
// bsst_cell: one slot of the sorted insertion chain
// Holds one value, compares it with the pending value and shifts right on
// insertion, taking its left neighbour's value or the new one.
// ---------------------------------------------------------------------------
module bsst_cell (
  input  logic                      clk_i,
  input  logic [bsst_pkg::IdxW-1:0] idx_i,
  input  logic [bsst_pkg::CntW-1:0] count_i,
  input  logic [bsst_pkg::ValW-1:0] x_i,
  input  logic                      insert_i,
  input  bsst_pkg::link_t           left_i,
  input  logic                      right_gt_i,
  output bsst_pkg::link_t           link_o,
  output bsst_pkg::pick_t           pick_o
);
  import bsst_pkg::*;

  logic [ValW-1:0] value_q, value_d;
  logic [CntW-1:0] idx_ext, idx_next;
  logic            occupied, gt, at_tail, wr_en;

  assign idx_ext  = {1'b0, idx_i};
  assign idx_next = idx_ext + CntW'(1);
  assign occupied = idx_ext < count_i;
  assign gt       = occupied && (order_key(value_q) > order_key(x_i));
  assign at_tail  = idx_ext == count_i;
  assign wr_en    = insert_i && (gt || at_tail);

  always_comb begin
    value_d = value_q;
    if (wr_en) begin
      value_d = left_i.gt ? left_i.value : x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.gt    = gt;
  assign link_o.value = value_q;

  // successor: first greater cell; predecessor: last cell not greater
  assign pick_o.succ = gt && !left_i.gt;
  assign pick_o.pred = occupied && !gt && ((idx_next == count_i) || right_gt_i);
  assign pick_o.last = occupied && (idx_next == count_i);

endmodule
